// File: design/grid_cell_resolve_core_macros.svh
// Assertion macros for the grid cell resolver.
// Used by the top level; expects clock and reset in scope.
`ifndef GRID_CELL_RESOLVE_CORE_MACROS_SVH
`define GRID_CELL_RESOLVE_CORE_MACROS_SVH
`define GCR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("grid cell resolve check failed");
`define GCR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("grid cell resolve check failed");
`endif

// File: design/gcr_pkg.sv
// Shared types and constants of the grid cell resolver.
// No dependencies.
package gcr_pkg;
   localparam int DEF_MAX_GRID = 64;
   localparam int DEF_COORD_BITS = 32;
   localparam int COUNT_W = 7;
   localparam int TOL_W = 31;
   localparam int INDEX_W = 6;
   localparam int REG_SEL_W = 3;

   typedef enum logic [REG_SEL_W-1:0] {
      REG_BOUNDS_VALID = 3'd0,
      REG_LEFT_EDGE = 3'd1,
      REG_RIGHT_EDGE = 3'd2,
      REG_TOP_EDGE = 3'd3,
      REG_BOTTOM_EDGE = 3'd4,
      REG_GRID_ROWS = 3'd5,
      REG_GRID_COLUMNS = 3'd6,
      REG_EDGE_TOLERANCE = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic valid;
      logic in_box;
      logic ok_x;
      logic ok_y;
   } cell_ctl_type;
endpackage

// File: design/gcr_if.sv
// Point and result channel interfaces of the grid cell resolver.
// No dependencies.
interface gcr_req_if #(parameter int COORD_BITS = 32);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic point_present;
   modport source (output valid, point_x, point_y, point_present, input ready);
   modport sink (input valid, point_x, point_y, point_present, output ready);
endinterface

interface gcr_rsp_if;
   logic valid;
   logic ready;
   logic cell_valid;
   logic [5:0] cell_row;
   logic [5:0] cell_column;
   logic box_hit;
   logic ambiguous;
   modport source (output valid, cell_valid, cell_row, cell_column, box_hit, ambiguous,
                   input ready);
   modport sink (input valid, cell_valid, cell_row, cell_column, box_hit, ambiguous,
                 output ready);
endinterface

// File: design/gcr_setup.sv
// Cell size unit: divides box width and height by the clamped counts, one bit a cycle.
// Depends on gcr_pkg.
module gcr_setup #(
   parameter int MAX_GRID = 64,
   parameter int COORD_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [COORD_BITS-1:0] left_edge,
   input  logic signed [COORD_BITS-1:0] right_edge,
   input  logic signed [COORD_BITS-1:0] top_edge,
   input  logic signed [COORD_BITS-1:0] bottom_edge,
   input  logic [gcr_pkg::COUNT_W-1:0] grid_rows,
   input  logic [gcr_pkg::COUNT_W-1:0] grid_columns,
   output logic [COORD_BITS-1:0] size_x,
   output logic [COORD_BITS-1:0] size_y,
   output logic [COORD_BITS+gcr_pkg::COUNT_W-1:0] limit_x,
   output logic [COORD_BITS+gcr_pkg::COUNT_W-1:0] limit_y,
   output logic busy
);
   import gcr_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int CNT_W = $clog2(CB + 1);
   localparam int CAP = (MAX_GRID < 127) ? MAX_GRID : 127;

   typedef enum logic [1:0] {S_LOAD, S_DIV, S_MUL, S_DONE} state_type;

   state_type state_ff;
   logic [CB-1:0] dv_x_ff, dv_y_ff;
   logic [COUNT_W:0] rem_x_ff, rem_y_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CB+COUNT_W-1:0] limit_x_ff, limit_y_ff;

   logic [COUNT_W-1:0] count_x, count_y;
   logic signed [CB:0] span_x, span_y;
   logic [CB-1:0] width_x_in, width_y_in;
   logic [COUNT_W:0] trial_x, trial_y;
   logic bit_x, bit_y;

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] n);
      if (n == '0) return COUNT_W'(1);
      if (n > COUNT_W'(CAP)) return COUNT_W'(CAP);
      return n;
   endfunction

   assign count_x = clamp_count(grid_columns);
   assign count_y = clamp_count(grid_rows);
   assign span_x = $signed({right_edge[CB-1], right_edge}) - $signed({left_edge[CB-1], left_edge});
   assign span_y = $signed({bottom_edge[CB-1], bottom_edge}) - $signed({top_edge[CB-1], top_edge});
   assign width_x_in = span_x[CB] ? '0 : span_x[CB-1:0];
   assign width_y_in = span_y[CB] ? '0 : span_y[CB-1:0];
   assign trial_x = {rem_x_ff[COUNT_W-1:0], dv_x_ff[CB-1]};
   assign trial_y = {rem_y_ff[COUNT_W-1:0], dv_y_ff[CB-1]};
   assign bit_x = trial_x >= {1'b0, count_x};
   assign bit_y = trial_y >= {1'b0, count_y};

   always_ff @(posedge clock) begin
      if (reset || start) begin
         state_ff <= S_LOAD;
      end else begin
         case (state_ff)
            S_LOAD: begin
               dv_x_ff <= width_x_in;
               dv_y_ff <= width_y_in;
               rem_x_ff <= '0;
               rem_y_ff <= '0;
               cnt_ff <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_x_ff <= bit_x ? trial_x - {1'b0, count_x} : trial_x;
               rem_y_ff <= bit_y ? trial_y - {1'b0, count_y} : trial_y;
               dv_x_ff <= {dv_x_ff[CB-2:0], bit_x};
               dv_y_ff <= {dv_y_ff[CB-2:0], bit_y};
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(CB - 1)) state_ff <= S_MUL;
            end
            S_MUL: begin
               limit_x_ff <= (CB+COUNT_W)'(dv_x_ff) * (CB+COUNT_W)'(count_x);
               limit_y_ff <= (CB+COUNT_W)'(dv_y_ff) * (CB+COUNT_W)'(count_y);
               state_ff <= S_DONE;
            end
            default: state_ff <= S_DONE;
         endcase
      end
   end

   assign size_x = dv_x_ff;
   assign size_y = dv_y_ff;
   assign limit_x = limit_x_ff;
   assign limit_y = limit_y_ff;
   assign busy = state_ff != S_DONE;
endmodule

// File: design/gcr_cell.sv
// One restoring division step on both axes, holding one point and taking one point per cycle while advance is high.
// Depends on gcr_pkg.
module gcr_cell #(
   parameter int COORD_BITS = 32,
   parameter int QUOT_BITS = 6,
   parameter int BIT_POS = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  gcr_pkg::cell_ctl_type ctl_in,
   input  logic [COORD_BITS-1:0] rem_x_in,
   input  logic [COORD_BITS-1:0] rem_y_in,
   input  logic [QUOT_BITS-1:0] q_x_in,
   input  logic [QUOT_BITS-1:0] q_y_in,
   input  logic [COORD_BITS-1:0] size_x,
   input  logic [COORD_BITS-1:0] size_y,
   output gcr_pkg::cell_ctl_type ctl_out,
   output logic [COORD_BITS-1:0] rem_x_out,
   output logic [COORD_BITS-1:0] rem_y_out,
   output logic [QUOT_BITS-1:0] q_x_out,
   output logic [QUOT_BITS-1:0] q_y_out
);
   import gcr_pkg::*;

   localparam int SW = COORD_BITS + QUOT_BITS;

   cell_ctl_type ctl_ff;
   logic [COORD_BITS-1:0] rem_x_ff, rem_y_ff, rem_x_in_w, rem_y_in_w;
   logic [QUOT_BITS-1:0] q_x_ff, q_y_ff;
   logic [SW-1:0] div_x, div_y, diff_x, diff_y;
   logic ge_x, ge_y;

   assign div_x = SW'(size_x) << BIT_POS;
   assign div_y = SW'(size_y) << BIT_POS;
   assign ge_x = SW'(rem_x_in) >= div_x;
   assign ge_y = SW'(rem_y_in) >= div_y;
   assign diff_x = SW'(rem_x_in) - div_x;
   assign diff_y = SW'(rem_y_in) - div_y;
   assign rem_x_in_w = ge_x ? diff_x[COORD_BITS-1:0] : rem_x_in;
   assign rem_y_in_w = ge_y ? diff_y[COORD_BITS-1:0] : rem_y_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_x_ff <= rem_x_in_w;
         rem_y_ff <= rem_y_in_w;
         q_x_ff <= q_x_in | (ge_x ? QUOT_BITS'(1) << BIT_POS : '0);
         q_y_ff <= q_y_in | (ge_y ? QUOT_BITS'(1) << BIT_POS : '0);
      end
   end

   assign ctl_out = ctl_ff;
   assign rem_x_out = rem_x_ff;
   assign rem_y_out = rem_y_ff;
   assign q_x_out = q_x_ff;
   assign q_y_out = q_y_ff;
endmodule

// File: design/grid_cell_resolve_core.sv
// Grid cell resolver: maps each floor point (signed Q16.16) to a row and column of the
// calibrated playable box. One point is accepted every cycle while the result channel and
// the cell size unit do not hold it; each point passes the entry register, one chain cell
// per quotient bit and the output register. After reset and after every register write the
// cell size unit divides the box by the counts one bit a cycle; no point is accepted until
// it finishes. Depends on gcr_pkg, gcr_if, gcr_setup, gcr_cell and the macros.
module grid_cell_resolve_core #(
   parameter int MAX_GRID = gcr_pkg::DEF_MAX_GRID,
   parameter int COORD_BITS = gcr_pkg::DEF_COORD_BITS,
   localparam int DATA_W = (COORD_BITS > 32) ? 64 : 32,
   localparam int ADDR_W = gcr_pkg::REG_SEL_W + ((DATA_W == 64) ? 3 : 2)
) (
   input  logic clock,
   input  logic reset,
   gcr_req_if.sink req_in,
   gcr_rsp_if.source rsp_out,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import gcr_pkg::*;
   `include "grid_cell_resolve_core_macros.svh"

   localparam int CB = COORD_BITS;
   localparam int CAP = (MAX_GRID < 127) ? MAX_GRID : 127;
   localparam int QB = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int LW = CB + COUNT_W;
   localparam int TW = ((CB > TOL_W) ? CB : TOL_W) + 1;

   logic bounds_ff;
   logic signed [CB-1:0] left_ff, right_ff, top_ff, bottom_ff;
   logic [COUNT_W-1:0] rows_ff, cols_ff;
   logic [TOL_W-1:0] tol_ff;
   reg_index_type reg_sel;
   logic cfg_wr;

   logic [CB-1:0] size_x, size_y;
   logic [LW-1:0] limit_x, limit_y;
   logic setup_busy;

   cell_ctl_type ctl_w [0:QB];
   logic [CB-1:0] rem_x_w [0:QB];
   logic [CB-1:0] rem_y_w [0:QB];
   logic [QB-1:0] q_x_w [0:QB];
   logic [QB-1:0] q_y_w [0:QB];
   logic adv [0:QB+1];

   cell_ctl_type ctl0_in;
   logic signed [CB:0] rel_x_full, rel_y_full;

   logic rsp_v_ff, cell_valid_ff, box_hit_ff, ambiguous_ff;
   logic [INDEX_W-1:0] row_ff, col_ff;
   logic clear_x, clear_y, cell_valid_in;

   assign reg_sel = reg_index_type'(csr_paddr[ADDR_W-1 -: REG_SEL_W]);
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff <= 1'b0;
         left_ff <= '0;
         right_ff <= '0;
         top_ff <= '0;
         bottom_ff <= '0;
         rows_ff <= COUNT_W'(1);
         cols_ff <= COUNT_W'(1);
         tol_ff <= '0;
      end else if (cfg_wr) begin
         case (reg_sel)
            REG_BOUNDS_VALID: bounds_ff <= csr_pwdata[0];
            REG_LEFT_EDGE: left_ff <= csr_pwdata[CB-1:0];
            REG_RIGHT_EDGE: right_ff <= csr_pwdata[CB-1:0];
            REG_TOP_EDGE: top_ff <= csr_pwdata[CB-1:0];
            REG_BOTTOM_EDGE: bottom_ff <= csr_pwdata[CB-1:0];
            REG_GRID_ROWS: rows_ff <= csr_pwdata[COUNT_W-1:0];
            REG_GRID_COLUMNS: cols_ff <= csr_pwdata[COUNT_W-1:0];
            REG_EDGE_TOLERANCE: tol_ff <= csr_pwdata[TOL_W-1:0];
            default: bounds_ff <= bounds_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_BOUNDS_VALID: csr_prdata = DATA_W'(bounds_ff);
         REG_LEFT_EDGE: csr_prdata = DATA_W'(left_ff);
         REG_RIGHT_EDGE: csr_prdata = DATA_W'(right_ff);
         REG_TOP_EDGE: csr_prdata = DATA_W'(top_ff);
         REG_BOTTOM_EDGE: csr_prdata = DATA_W'(bottom_ff);
         REG_GRID_ROWS: csr_prdata = DATA_W'(rows_ff);
         REG_GRID_COLUMNS: csr_prdata = DATA_W'(cols_ff);
         REG_EDGE_TOLERANCE: csr_prdata = DATA_W'(tol_ff);
         default: csr_prdata = '0;
      endcase
   end

   gcr_setup #(.MAX_GRID(MAX_GRID), .COORD_BITS(COORD_BITS)) u_setup (
      .clock(clock),
      .reset(reset),
      .start(cfg_wr),
      .left_edge(left_ff),
      .right_edge(right_ff),
      .top_edge(top_ff),
      .bottom_edge(bottom_ff),
      .grid_rows(rows_ff),
      .grid_columns(cols_ff),
      .size_x(size_x),
      .size_y(size_y),
      .limit_x(limit_x),
      .limit_y(limit_y),
      .busy(setup_busy)
   );

   assign req_in.ready = adv[0] && !setup_busy;

   assign rel_x_full = $signed({req_in.point_x[CB-1], req_in.point_x})
                     - $signed({left_ff[CB-1], left_ff});
   assign rel_y_full = $signed({req_in.point_y[CB-1], req_in.point_y})
                     - $signed({top_ff[CB-1], top_ff});

   always_comb begin
      ctl0_in.valid = req_in.valid && !setup_busy;
      ctl0_in.in_box = req_in.point_present && bounds_ff
                    && req_in.point_x >= left_ff && req_in.point_x <= right_ff
                    && req_in.point_y >= top_ff && req_in.point_y <= bottom_ff;
      ctl0_in.ok_x = size_x != '0 && LW'(rel_x_full[CB-1:0]) < limit_x;
      ctl0_in.ok_y = size_y != '0 && LW'(rel_y_full[CB-1:0]) < limit_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_w[0] <= '0;
      end else if (adv[0]) begin
         ctl_w[0] <= ctl0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_x_w[0] <= rel_x_full[CB-1:0];
         rem_y_w[0] <= rel_y_full[CB-1:0];
      end
   end

   assign q_x_w[0] = '0;
   assign q_y_w[0] = '0;

   for (genvar k = 0; k <= QB; k++) begin : g_adv
      assign adv[k] = !ctl_w[k].valid || adv[k+1];
   end
   assign adv[QB+1] = !rsp_v_ff || rsp_out.ready;

   for (genvar k = 0; k < QB; k++) begin : g_cell
      gcr_cell #(.COORD_BITS(COORD_BITS), .QUOT_BITS(QB), .BIT_POS(QB - 1 - k)) u_cell (
         .clock(clock),
         .reset(reset),
         .advance(adv[k+1]),
         .ctl_in(ctl_w[k]),
         .rem_x_in(rem_x_w[k]),
         .rem_y_in(rem_y_w[k]),
         .q_x_in(q_x_w[k]),
         .q_y_in(q_y_w[k]),
         .size_x(size_x),
         .size_y(size_y),
         .ctl_out(ctl_w[k+1]),
         .rem_x_out(rem_x_w[k+1]),
         .rem_y_out(rem_y_w[k+1]),
         .q_x_out(q_x_w[k+1]),
         .q_y_out(q_y_w[k+1])
      );
   end

   assign clear_x = TW'(rem_x_w[QB]) > TW'(tol_ff)
                 && (TW'(size_x) - TW'(rem_x_w[QB])) > TW'(tol_ff);
   assign clear_y = TW'(rem_y_w[QB]) > TW'(tol_ff)
                 && (TW'(size_y) - TW'(rem_y_w[QB])) > TW'(tol_ff);
   assign cell_valid_in = ctl_w[QB].in_box && ctl_w[QB].ok_x && ctl_w[QB].ok_y
                       && clear_x && clear_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv[QB+1]) begin
         rsp_v_ff <= ctl_w[QB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[QB+1]) begin
         cell_valid_ff <= cell_valid_in;
         row_ff <= cell_valid_in ? INDEX_W'(q_y_w[QB]) : '0;
         col_ff <= cell_valid_in ? INDEX_W'(q_x_w[QB]) : '0;
         box_hit_ff <= ctl_w[QB].in_box;
         ambiguous_ff <= ctl_w[QB].in_box && !cell_valid_in;
      end
   end

   assign rsp_out.valid = rsp_v_ff;
   assign rsp_out.cell_valid = cell_valid_ff;
   assign rsp_out.cell_row = row_ff;
   assign rsp_out.cell_column = col_ff;
   assign rsp_out.box_hit = box_hit_ff;
   assign rsp_out.ambiguous = ambiguous_ff;

   `GCR_ASSERT_NEXT(a_write_restarts_setup, cfg_wr, setup_busy)
   `GCR_ASSERT_SAME(a_invalid_cell_zero, rsp_v_ff && !cell_valid_ff, row_ff == '0 && col_ff == '0)
   `GCR_ASSERT_SAME(a_ambiguous_in_box, rsp_v_ff && ambiguous_ff, box_hit_ff && !cell_valid_ff)
endmodule

// File: sim/testbench.sv
// Self-checking bench for grid_cell_resolve_core: drives floor points, predicts each cell.
// Depends on gcr_pkg, gcr_if and the block's RTL.
`timescale 1ns / 100ps

module testbench;
   import gcr_pkg::*;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic present;
   } point_type;

   typedef struct packed {
      logic cell_valid;
      logic [5:0] cell_row;
      logic [5:0] cell_column;
      logic box_hit;
      logic ambiguous;
   } cell_type;

   localparam longint COORD_MIN = -64'sd2147483648;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [4:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   gcr_req_if #(32) req ();
   gcr_rsp_if rsp ();

   grid_cell_resolve_core uut (
      .clock(clock), .reset(reset), .req_in(req), .rsp_out(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // shadow of the block's registers
   bit cfg_bounds;
   longint cfg_left, cfg_right, cfg_top, cfg_bottom, cfg_tol;
   logic [6:0] cfg_rows, cfg_cols;

   point_type point_backlog[$];
   cell_type cell_expect[$];
   int failures;
   int cycles;
   bit idle_on;
   int send_gap;
   int recv_stall;

   function automatic longint grid_count(logic [6:0] n);
      if (n == 0) return 1;
      if (n > DEF_MAX_GRID) return DEF_MAX_GRID;
      return n;
   endfunction

   function automatic bit axis_cell(longint pos, longint lo, longint hi, longint count,
                                    output longint idx);
      longint size, rel, rem, quot;
      idx = 0;
      size = (hi - lo) / count;
      rel = pos - lo;
      if (size <= 0) return 0;
      rem = rel % size;
      quot = rel / size;
      if (rem <= cfg_tol || (size - rem) <= cfg_tol) return 0;
      if (quot < 0 || quot >= count) return 0;
      idx = quot;
      return 1;
   endfunction

   function automatic cell_type predict_cell(point_type p);
      cell_type c;
      longint px, py, ri, ci;
      bit in_box, ok;
      px = p.x;
      py = p.y;
      c = '0;
      in_box = p.present && cfg_bounds && px >= cfg_left && px <= cfg_right
               && py >= cfg_top && py <= cfg_bottom;
      ok = 0;
      if (in_box) begin
         ok = axis_cell(px, cfg_left, cfg_right, grid_count(cfg_cols), ci);
         if (ok) ok = axis_cell(py, cfg_top, cfg_bottom, grid_count(cfg_rows), ri);
      end
      if (ok) begin
         c.cell_valid = 1;
         c.cell_row = ri[5:0];
         c.cell_column = ci[5:0];
      end
      c.box_hit = in_box;
      c.ambiguous = in_box && !ok;
      return c;
   endfunction

   function automatic longint clip(longint v);
      if (v < COORD_MIN) return COORD_MIN;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   function automatic longint rand_between(longint lo, longint hi);
      longint unsigned r;
      if (hi <= lo) return lo;
      r = {$urandom, $urandom};
      return lo + longint'(r % longint'(hi - lo + 1));
   endfunction

   // mostly inside the box, some near cell edges, some anywhere
   function automatic logic signed [31:0] pick_coord(longint lo, longint hi, longint count);
      longint size, v;
      int mode;
      mode = $urandom_range(0, 9);
      size = (hi - lo) / count;
      if (mode < 2 || hi < lo)
         v = longint'($signed($urandom));
      else if (mode < 5 && size > 0)
         v = lo + longint'($urandom_range(0, count)) * size
             + rand_between(-cfg_tol - 2, cfg_tol + 2);
      else if (mode == 5)
         v = ($urandom_range(0, 1) ? hi : lo) + longint'($urandom_range(0, 2)) - 1;
      else
         v = rand_between(lo, hi);
      v = clip(v);
      return v[31:0];
   endfunction

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
         send_gap <= 0;
      end else begin
         if (req.valid && req.ready)
            cell_expect.push_back(predict_cell('{req.point_x, req.point_y, req.point_present}));
         if (!(req.valid && !req.ready)) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req.valid <= 0;
            end else if (idle_on && point_backlog.size() > 0 && $urandom_range(0, 7) == 0) begin
               send_gap <= $urandom_range(0, 4);
               req.valid <= 0;
            end else if (point_backlog.size() > 0) begin
               point_type p;
               p = point_backlog.pop_front();
               req.point_x <= p.x;
               req.point_y <= p.y;
               req.point_present <= p.present;
               req.valid <= 1;
            end else begin
               req.valid <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
         recv_stall <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (cell_expect.size() == 0) begin
               $error("unexpected result word");
               failures++;
            end else begin
               cell_type e;
               e = cell_expect.pop_front();
               if (rsp.cell_valid !== e.cell_valid) begin
                  $error("cell_valid expected %0d got %0d", e.cell_valid, rsp.cell_valid);
                  failures++;
               end
               if (rsp.cell_row !== e.cell_row) begin
                  $error("cell_row expected %0d got %0d", e.cell_row, rsp.cell_row);
                  failures++;
               end
               if (rsp.cell_column !== e.cell_column) begin
                  $error("cell_column expected %0d got %0d", e.cell_column, rsp.cell_column);
                  failures++;
               end
               if (rsp.box_hit !== e.box_hit) begin
                  $error("box_hit expected %0d got %0d", e.box_hit, rsp.box_hit);
                  failures++;
               end
               if (rsp.ambiguous !== e.ambiguous) begin
                  $error("ambiguous expected %0d got %0d", e.ambiguous, rsp.ambiguous);
                  failures++;
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp.ready <= 0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            recv_stall <= $urandom_range(0, 4);
            rsp.ready <= 0;
         end else begin
            rsp.ready <= 1;
         end
      end
   end

   task automatic drain();
      while (point_backlog.size() > 0 || req.valid || cell_expect.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] v);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         REG_BOUNDS_VALID: cfg_bounds = v[0];
         REG_LEFT_EDGE: cfg_left = longint'($signed(v));
         REG_RIGHT_EDGE: cfg_right = longint'($signed(v));
         REG_TOP_EDGE: cfg_top = longint'($signed(v));
         REG_BOTTOM_EDGE: cfg_bottom = longint'($signed(v));
         REG_GRID_ROWS: cfg_rows = v[6:0];
         REG_GRID_COLUMNS: cfg_cols = v[6:0];
         REG_EDGE_TOLERANCE: cfg_tol = v[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_box(bit bv, longint l, longint r, longint t, longint b,
                          int rows, int cols, longint tol);
      drain();
      csr_write(REG_BOUNDS_VALID, 32'(bv));
      csr_write(REG_LEFT_EDGE, l[31:0]);
      csr_write(REG_RIGHT_EDGE, r[31:0]);
      csr_write(REG_TOP_EDGE, t[31:0]);
      csr_write(REG_BOTTOM_EDGE, b[31:0]);
      csr_write(REG_GRID_ROWS, 32'(rows));
      csr_write(REG_GRID_COLUMNS, 32'(cols));
      csr_write(REG_EDGE_TOLERANCE, tol[31:0]);
   endtask

   task automatic add_point(longint x, longint y, bit present);
      point_backlog.push_back('{x[31:0], y[31:0], present});
   endtask

   initial begin
      longint l, r, t, b, lo, hi, a, span;
      int rows, cols;
      failures = 0;
      cycles = 0;
      idle_on = 1;
      reset = 1;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req.valid = 0;
      req.point_x = '0;
      req.point_y = '0;
      req.point_present = 0;
      rsp.ready = 0;
      cfg_bounds = 0; cfg_left = 0; cfg_right = 0; cfg_top = 0; cfg_bottom = 0;
      cfg_rows = 1; cfg_cols = 1; cfg_tol = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // uncalibrated box
      add_point(0, 0, 1);
      add_point(COORD_MAX, COORD_MIN, 1);

      // 4x4 box of +/-10, cell 5.0, tolerance 1/16
      set_box(1, -655360, 655360, -655360, 655360, 4, 4, 4096);
      add_point(-655361, 0, 1);
      add_point(-655360, -655360, 1);
      add_point(-491520, -491520, 1);
      add_point(-491520, 491520, 0);
      add_point(655360, 655360, 1);
      add_point(0, 163840, 1);
      add_point(-327680 + 4096, 163840, 1);
      add_point(-327680 + 4097, 163840, 1);
      add_point(163840, -655360 + 327680 - 4096, 1);
      add_point(163840, -655360 + 327680 - 4097, 1);
      add_point(163840, 655361, 1);

      // whole coordinate range, row count above the grid, column count zero
      set_box(1, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 127, 0, 0);
      add_point(COORD_MIN, COORD_MIN, 1);
      add_point(COORD_MAX, COORD_MAX, 1);
      add_point(0, 12345, 1);
      add_point(-1, 1, 1);

      // cell size truncated to zero, widest tolerance
      set_box(1, 0, 10, 0, 10, 64, 64, 0);
      add_point(5, 5, 1);
      set_box(1, -65536, 65536, -65536, 65536, 1, 1, 64'h7FFFFFFF);
      add_point(0, 0, 1);

      // inverted box
      set_box(1, 65536, -65536, -65536, 65536, 2, 2, 0);
      add_point(0, 0, 1);
      add_point(65536, 0, 1);
      drain();

      for (int phase = 0; phase < 9; phase++) begin
         a = longint'($signed($urandom));
         case ($urandom_range(0, 3))
            0: span = $urandom_range(0, 1000);
            1: span = $urandom_range(0, 1 << 20);
            2: span = $urandom_range(1 << 20, 1 << 26);
            default: span = $urandom;
         endcase
         l = a; r = clip(a + span);
         a = longint'($signed($urandom));
         span = ($urandom_range(0, 1)) ? longint'($urandom_range(0, 1 << 24)) : longint'($urandom);
         t = a; b = clip(a + span);
         if ($urandom_range(0, 9) == 0) begin
            lo = l; l = r; r = lo;
         end
         rows = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
         cols = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
         hi = (r - l) / grid_count(cols);
         lo = $urandom_range(0, 9) == 0 ? longint'($urandom_range(0, 32'h7FFFFFFF))
              : (hi > 4 ? rand_between(0, hi / 4) : 0);
         set_box($urandom_range(0, 9) != 0, l, r, t, b, rows, cols, lo);
         idle_on = (phase < 8) && $urandom_range(0, 3) != 0;
         for (int i = 0; i < 100; i++)
            point_backlog.push_back('{pick_coord(cfg_left, cfg_right, grid_count(cfg_cols)),
                                      pick_coord(cfg_top, cfg_bottom, grid_count(cfg_rows)),
                                      $urandom_range(0, 9) != 0});
         if (phase == 8) idle_on = 0;
      end

      drain();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule

// File: sim.f
+incdir+design
design/gcr_pkg.sv
design/gcr_if.sv
design/gcr_setup.sv
design/gcr_cell.sv
design/grid_cell_resolve_core.sv
sim/testbench.sv
